// ===== sv/sfd_pkg.sv =====
// shared types and constants of the stiff string finite-difference step
`default_nettype none
package sfd_pkg;

   // external fixed-point formats
   localparam int Q230_W      = 32;
   localparam int COEF_W      = 32;
   localparam int COEF_FRAC   = 28;
   localparam int OPCODE_W    = 2;
   localparam int POINT_W     = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // opcodes of a request beat
   localparam logic [OPCODE_W-1:0] OP_STEP = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_CENTRE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_NEAR        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_FAR         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_PREV_CENTRE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_PREV_NEAR   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENTS         = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PICKUP_POINT     = 3'd6;

   // stencil weights, Q4.28
   typedef struct packed {
      logic signed [COEF_W-1:0] centre;
      logic signed [COEF_W-1:0] near;
      logic signed [COEF_W-1:0] far;
      logic signed [COEF_W-1:0] prev_centre;
      logic signed [COEF_W-1:0] prev_near;
   } sfd_coef_type;

endpackage
`default_nettype wire

// ===== sv/sfd_if.sv =====
// request, response and register write channels
`default_nettype none
interface sfd_req_if;
   import sfd_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic [POINT_W-1:0]         point;
   logic signed [Q230_W-1:0]   amount;
   modport source (output valid, opcode, point, amount, input ready);
   modport sink   (input valid, opcode, point, amount, output ready);
endinterface

interface sfd_rsp_if;
   import sfd_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [Q230_W-1:0]   displacement;
   logic                       saturated;
   modport source (output valid, displacement, saturated, input ready);
   modport sink   (input valid, displacement, saturated, output ready);
endinterface

interface sfd_csr_if;
   import sfd_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_W-1:0]     index;
   logic [CSR_DATA_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/sfd_grid_mem.sv =====
// one displacement vector: single write port, registered read port
`default_nettype none
module sfd_grid_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and synchronous read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== sv/sfd_weigh_pipe.sv =====
// four-stage eight-tap weighted sum with saturation
`default_nettype none
module sfd_weigh_pipe #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int TAG_WIDTH    = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic [TAG_WIDTH-1:0]           in_tag,
   input  wire sfd_pkg::sfd_coef_type          coef,
   input  wire logic signed [SAMPLE_WIDTH-1:0] cur_win [5],
   input  wire logic signed [SAMPLE_WIDTH-1:0] prv_win [3],
   output logic                                out_valid,
   output logic [TAG_WIDTH-1:0]                out_tag,
   output logic signed [SAMPLE_WIDTH-1:0]      out_sample,
   output logic                                out_clip
);
   import sfd_pkg::*;

   localparam int SW   = SAMPLE_WIDTH;
   localparam int LO_W = SW / 2;
   localparam int HI_W = SW - LO_W;
   localparam int PW   = SW + COEF_W;
   localparam int TW   = SW + 4;
   localparam int AW   = SW + 5;
   localparam int SUMW = SW + 7;

   logic signed [SW-1:0]          x [8];
   logic signed [COEF_W-1:0]      c [8];
   logic signed [LO_W+COEF_W:0]   plo_ff [8];
   logic signed [HI_W+COEF_W-1:0] phi_ff [8];
   logic signed [PW-1:0]          full [8];
   logic signed [TW-1:0]          term_ff [8];
   logic signed [AW-1:0]          pair_ff [4];
   logic signed [SUMW-1:0]        total;
   logic signed [SUMW-1:0]        hi_lim;
   logic signed [SUMW-1:0]        lo_lim;
   logic [2:0]                    vld_ff;
   logic [TAG_WIDTH-1:0]          tag_ff [3];

   // tap selection
   always_comb begin
      x[0] = cur_win[2]; c[0] = coef.centre;
      x[1] = cur_win[1]; c[1] = coef.near;
      x[2] = cur_win[3]; c[2] = coef.near;
      x[3] = cur_win[0]; c[3] = coef.far;
      x[4] = cur_win[4]; c[4] = coef.far;
      x[5] = prv_win[1]; c[5] = coef.prev_centre;
      x[6] = prv_win[0]; c[6] = coef.prev_near;
      x[7] = prv_win[2]; c[7] = coef.prev_near;
   end

   // recombine split products, floor to sample resolution
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         full[j] = (PW'(phi_ff[j]) <<< LO_W) + PW'(plo_ff[j]);
      end
   end

   // final sum and clip limits
   assign total  = SUMW'(pair_ff[0]) + SUMW'(pair_ff[1]) + SUMW'(pair_ff[2])
                 + SUMW'(pair_ff[3]);
   assign hi_lim = $signed({8'd0, {(SW-1){1'b1}}});
   assign lo_lim = ~hi_lim;

   // datapath stages
   always_ff @(posedge clock) begin
      for (int j = 0; j < 8; j++) begin
         plo_ff[j]  <= $signed({1'b0, x[j][LO_W-1:0]}) * c[j];
         phi_ff[j]  <= $signed(x[j][SW-1:LO_W]) * c[j];
         term_ff[j] <= TW'(full[j] >>> COEF_FRAC);
      end
      for (int k = 0; k < 4; k++) begin
         pair_ff[k] <= AW'(term_ff[2*k]) + AW'(term_ff[2*k+1]);
      end
      if (total > hi_lim) begin
         out_sample <= hi_lim[SW-1:0];
         out_clip   <= 1'b1;
      end else if (total < lo_lim) begin
         out_sample <= lo_lim[SW-1:0];
         out_clip   <= 1'b1;
      end else begin
         out_sample <= total[SW-1:0];
         out_clip   <= 1'b0;
      end
      tag_ff[0] <= in_tag;
      for (int k = 1; k < 3; k++) begin
         tag_ff[k] <= tag_ff[k-1];
      end
      out_tag <= tag_ff[2];
   end

   // valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         out_valid <= 1'b0;
      end else begin
         vld_ff    <= {vld_ff[1:0], in_valid};
         out_valid <= vld_ff[2];
      end
   end
endmodule
`default_nettype wire

// ===== sv/stiff_string_fd_step.sv =====
// stiff string time step: add/read go from accept through ST_OPDATA and ST_DONE to the response beat,
// a step walks all MAX_POINTS grid points one a cycle through the memories and a
// 4-stage weighting pipeline, then reports the pickup.
// one request at a time; the next is taken while the last response beat waits.
// synchronous reset clears the control registers (segments goes to 255), then zeroes
// all three grid memories one address a cycle, during which no request is accepted.
`default_nettype none
module stiff_string_fd_step #(
   parameter int MAX_POINTS   = 256,
   parameter int SAMPLE_WIDTH = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sfd_req_if.sink    req_if,
   sfd_rsp_if.source  rsp_if,
   sfd_csr_if.sink    csr_if
);
   import sfd_pkg::*;

   localparam int SW    = SAMPLE_WIDTH;
   localparam int LW    = $clog2(MAX_POINTS);
   localparam int IW    = LW + 1;
   localparam int NW    = ((LW > POINT_W) ? LW : POINT_W) + 1;
   localparam int W2    = SW + 33;
   localparam int SHL   = (SW >= Q230_W) ? SW - Q230_W : 0;
   localparam int SHR   = (SW >= Q230_W) ? 0 : Q230_W - SW;
   localparam int TAG_W = LW + 2;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_STEP, ST_DRAIN, ST_PICK, ST_OPDATA, ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [IW-1:0]        rd_idx_ff, rd_idx_in;
   logic [1:0]           rot_ff, rot_in;
   logic [OPCODE_W-1:0]  op_ff, op_in;
   logic                 pt_ok_ff, pt_ok_in;
   logic [LW-1:0]        addr_ff, addr_in;
   logic signed [SW-1:0] amount_ff, amount_in;
   logic                 rdv_ff, rdv_in;
   logic [IW-1:0]        rdq_idx_ff, rdq_idx_in;
   logic signed [SW-1:0] cwin_ff [4];
   logic signed [SW-1:0] cwin_in [4];
   logic signed [SW-1:0] pwin_ff [3];
   logic signed [SW-1:0] pwin_in [3];
   logic                 clip_ff, clip_in;
   logic [Q230_W-1:0]    res_disp_ff, res_disp_in;
   logic                 res_sat_ff, res_sat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [Q230_W-1:0]    rsp_disp_ff, rsp_disp_in;
   logic                 rsp_sat_ff, rsp_sat_in;
   sfd_coef_type         coef_ff, coef_in;
   logic [POINT_W-1:0]   segments_ff, segments_in;
   logic [POINT_W-1:0]   pickup_ff, pickup_in;

   logic                 mem_we    [3];
   logic [LW-1:0]        mem_waddr [3];
   logic [SW-1:0]        mem_wdata [3];
   logic [SW-1:0]        mem_rdata [3];
   logic [LW-1:0]        rd_addr;
   logic [1:0]           cur_sel;
   logic [1:0]           prv_sel;
   logic signed [SW-1:0] cur_rd;
   logic signed [SW-1:0] prv_rd;

   logic [NW-1:0]        req_pt_n;
   logic [NW-1:0]        pick_n;
   logic [NW-1:0]        seg_n;
   logic [NW-1:0]        n_eff;
   logic [NW-1:0]        l_n;
   logic [IW-1:0]        l_full;
   logic signed [W2-1:0] amt_ext;
   logic signed [W2-1:0] amt_cv;
   logic signed [SW:0]   sum_cur;
   logic signed [SW:0]   sum_prv;
   logic signed [SW-1:0] add_cur;
   logic signed [SW-1:0] add_prv;
   logic                 add_clip;
   logic                 req_fire;

   logic                 pin_valid;
   logic [TAG_W-1:0]     pin_tag;
   logic signed [SW-1:0] pin_cur [5];
   logic signed [SW-1:0] pin_prv [3];
   logic                 pout_valid;
   logic [TAG_W-1:0]     pout_tag;
   logic signed [SW-1:0] pout_sample;
   logic                 pout_clip;
   logic                 pout_last;
   logic                 pout_int;
   logic [LW-1:0]        pout_l;

   // conversion of a sample to the Q2.30 output format
   function automatic logic [Q230_W-1:0] to_q230(input logic signed [SW-1:0] v);
      logic signed [W2-1:0] ext;
      logic signed [W2-1:0] sh;
      ext = W2'(v);
      sh  = (ext <<< SHR) >>> SHL;
      return sh[Q230_W-1:0];
   endfunction

   // roles of the three stores
   always_comb begin
      case (rot_ff)
         2'd0:    begin cur_sel = 2'd1; prv_sel = 2'd2; end
         2'd1:    begin cur_sel = 2'd2; prv_sel = 2'd0; end
         default: begin cur_sel = 2'd0; prv_sel = 2'd1; end
      endcase
   end

   assign cur_rd = mem_rdata[cur_sel];
   assign prv_rd = mem_rdata[prv_sel];

   // index arithmetic
   assign req_pt_n = NW'(req_if.point);
   assign pick_n   = NW'(pickup_ff);
   assign seg_n    = NW'(segments_ff);
   assign n_eff    = (seg_n > NW'(MAX_POINTS - 1)) ? NW'(MAX_POINTS - 1) : seg_n;
   assign l_full   = rdq_idx_ff - IW'(2);
   assign l_n      = NW'(l_full[LW-1:0]);

   // amount into sample format
   assign amt_ext = W2'(req_if.amount);
   assign amt_cv  = (amt_ext <<< SHL) >>> SHR;

   // add operation sums with saturation
   assign sum_cur  = (SW+1)'(cur_rd) + (SW+1)'(amount_ff);
   assign sum_prv  = (SW+1)'(prv_rd) + (SW+1)'(amount_ff);
   assign add_cur  = (sum_cur[SW] != sum_cur[SW-1]) ? {sum_cur[SW], {(SW-1){~sum_cur[SW]}}}
                                                    : sum_cur[SW-1:0];
   assign add_prv  = (sum_prv[SW] != sum_prv[SW-1]) ? {sum_prv[SW], {(SW-1){~sum_prv[SW]}}}
                                                    : sum_prv[SW-1:0];
   assign add_clip = (sum_cur[SW] != sum_cur[SW-1]) || (sum_prv[SW] != sum_prv[SW-1]);

   // read address shared by all stores
   always_comb begin
      case (state_ff)
         ST_IDLE: rd_addr = req_pt_n[LW-1:0];
         ST_PICK: rd_addr = pick_n[LW-1:0];
         default: rd_addr = (rd_idx_ff < IW'(MAX_POINTS)) ? rd_idx_ff[LW-1:0] : '0;
      endcase
   end

   // stencil window into the weighting pipeline
   assign pin_valid = rdv_ff && (rdq_idx_ff >= IW'(2));
   assign pin_tag   = {(rdq_idx_ff == IW'(MAX_POINTS + 1)),
                       ((l_n >= NW'(2)) && (l_n + NW'(2) <= n_eff)),
                       l_full[LW-1:0]};
   assign pin_cur[4] = cur_rd;
   assign pin_cur[3] = cwin_ff[0];
   assign pin_cur[2] = cwin_ff[1];
   assign pin_cur[1] = cwin_ff[2];
   assign pin_cur[0] = cwin_ff[3];
   assign pin_prv[2] = pwin_ff[0];
   assign pin_prv[1] = pwin_ff[1];
   assign pin_prv[0] = pwin_ff[2];

   assign pout_last = pout_tag[LW+1];
   assign pout_int  = pout_tag[LW];
   assign pout_l    = pout_tag[LW-1:0];

   sfd_weigh_pipe #(
      .SAMPLE_WIDTH (SW),
      .TAG_WIDTH    (TAG_W)
   ) u_weigh (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pin_valid),
      .in_tag     (pin_tag),
      .coef       (coef_ff),
      .cur_win    (pin_cur),
      .prv_win    (pin_prv),
      .out_valid  (pout_valid),
      .out_tag    (pout_tag),
      .out_sample (pout_sample),
      .out_clip   (pout_clip)
   );

   // write ports: clearing pass, step results, add updates
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mem_we[i]    = 1'b0;
         mem_waddr[i] = addr_ff;
         mem_wdata[i] = '0;
         if (state_ff == ST_CLEAR) begin
            mem_we[i]    = 1'b1;
            mem_waddr[i] = rd_idx_ff[LW-1:0];
         end else if (pout_valid && (rot_ff == 2'(i))) begin
            mem_we[i]    = 1'b1;
            mem_waddr[i] = pout_l;
            mem_wdata[i] = pout_int ? pout_sample : '0;
         end else if ((state_ff == ST_OPDATA) && (op_ff == OP_ADD) && pt_ok_ff) begin
            if (cur_sel == 2'(i)) begin
               mem_we[i]    = 1'b1;
               mem_wdata[i] = add_cur;
            end else if (prv_sel == 2'(i)) begin
               mem_we[i]    = 1'b1;
               mem_wdata[i] = add_prv;
            end
         end
      end
   end

   // grid stores
   for (genvar g = 0; g < 3; g++) begin : g_store
      sfd_grid_mem #(
         .DEPTH (MAX_POINTS),
         .WIDTH (SW)
      ) u_mem (
         .clock    (clock),
         .we       (mem_we[g]),
         .waddr    (mem_waddr[g]),
         .wdata    (mem_wdata[g]),
         .raddr    (rd_addr),
         .rdata_ff (mem_rdata[g])
      );
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign csr_if.ready        = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.displacement = rsp_disp_ff;
   assign rsp_if.saturated    = rsp_sat_ff;
   assign req_fire            = req_if.valid && req_if.ready;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      rot_in       = rot_ff;
      op_in        = op_ff;
      pt_ok_in     = pt_ok_ff;
      addr_in      = addr_ff;
      amount_in    = amount_ff;
      clip_in      = clip_ff;
      res_disp_in  = res_disp_ff;
      res_sat_in   = res_sat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_disp_in  = rsp_disp_ff;
      rsp_sat_in   = rsp_sat_ff;
      coef_in      = coef_ff;
      segments_in  = segments_ff;
      pickup_in    = pickup_ff;
      rdv_in       = (state_ff == ST_STEP);
      rdq_idx_in   = rd_idx_ff;
      cwin_in      = cwin_ff;
      pwin_in      = pwin_ff;

      // register writes
      if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CSR_COEF_CENTRE:      coef_in.centre      = csr_if.data;
            CSR_COEF_NEAR:        coef_in.near        = csr_if.data;
            CSR_COEF_FAR:         coef_in.far         = csr_if.data;
            CSR_COEF_PREV_CENTRE: coef_in.prev_centre = csr_if.data;
            CSR_COEF_PREV_NEAR:   coef_in.prev_near   = csr_if.data;
            CSR_SEGMENTS:         segments_in         = csr_if.data[POINT_W-1:0];
            CSR_PICKUP_POINT:     pickup_in           = csr_if.data[POINT_W-1:0];
            default:              ;
         endcase
      end

      // sliding windows over current and previous vectors
      if (rdv_ff) begin
         cwin_in[0] = cur_rd;
         cwin_in[1] = cwin_ff[0];
         cwin_in[2] = cwin_ff[1];
         cwin_in[3] = cwin_ff[2];
         pwin_in[0] = prv_rd;
         pwin_in[1] = pwin_ff[0];
         pwin_in[2] = pwin_ff[1];
      end

      // clip flag over the whole step
      if (pout_valid && pout_int && pout_clip) begin
         clip_in = 1'b1;
      end

      // response beat taken
      if (rsp_if.valid && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            rd_idx_in = rd_idx_ff + IW'(1);
            if (rd_idx_ff == IW'(MAX_POINTS - 1)) begin
               rd_idx_in = '0;
               state_in  = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_if.opcode;
               pt_ok_in  = (req_pt_n < NW'(MAX_POINTS));
               addr_in   = req_pt_n[LW-1:0];
               amount_in = amt_cv[SW-1:0];
               clip_in   = 1'b0;
               rd_idx_in = '0;
               state_in  = (req_if.opcode == OP_STEP) ? ST_STEP : ST_OPDATA;
            end
         end
         ST_STEP: begin
            rd_idx_in = rd_idx_ff + IW'(1);
            if (rd_idx_ff == IW'(MAX_POINTS + 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pout_valid && pout_last) begin
               rot_in   = (rot_ff == 2'd0) ? 2'd2 : rot_ff - 2'd1;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            pt_ok_in = (pick_n < NW'(MAX_POINTS));
            state_in = ST_OPDATA;
         end
         ST_OPDATA: begin
            case (op_ff)
               OP_STEP: begin
                  res_disp_in = pt_ok_ff ? to_q230(cur_rd) : '0;
                  res_sat_in  = clip_ff;
               end
               OP_ADD: begin
                  res_disp_in = pt_ok_ff ? to_q230(add_cur) : '0;
                  res_sat_in  = pt_ok_ff && add_clip;
               end
               default: begin
                  res_disp_in = pt_ok_ff ? to_q230(cur_rd) : '0;
                  res_sat_in  = 1'b0;
               end
            endcase
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_disp_in  = res_disp_ff;
               rsp_sat_in   = res_sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rd_idx_ff    <= '0;
         rot_ff       <= 2'd0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clip_ff      <= 1'b0;
         coef_ff      <= '0;
         segments_ff  <= 8'd255;
         pickup_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         rot_ff       <= rot_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
         clip_ff      <= clip_in;
         coef_ff      <= coef_in;
         segments_ff  <= segments_in;
         pickup_ff    <= pickup_in;
      end
      op_ff       <= op_in;
      pt_ok_ff    <= pt_ok_in;
      addr_ff     <= addr_in;
      amount_ff   <= amount_in;
      rdq_idx_ff  <= rdq_idx_in;
      cwin_ff     <= cwin_in;
      pwin_ff     <= pwin_in;
      res_disp_ff <= res_disp_in;
      res_sat_ff  <= res_sat_in;
      rsp_disp_ff <= rsp_disp_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   // current and previous stores are only read while a step walks the grid
   a_step_no_src_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (!mem_we[cur_sel] && !mem_we[prv_sel]))
      else $error("source store written during step");

   // pipeline results only appear inside a step
   a_pipe_in_step: assert property (@(posedge clock) disable iff (reset)
      pout_valid |-> ((state_ff == ST_STEP) || (state_ff == ST_DRAIN)))
      else $error("weighting result outside step");

   // rotation stays within three roles
   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      rot_ff != 2'd3)
      else $error("rotation out of range");

   // a new response beat is only loaded once the old one is gone
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> (rsp_valid_ff && $stable(rsp_disp_ff)))
      else $error("pending response overwritten");
endmodule
`default_nettype wire

// ===== bench/stiff_string_fd_step_tb.sv =====
// self-checking testbench of the stiff string finite-difference step block
`timescale 1ns / 1ps
module stiff_string_fd_step_tb;
   import sfd_pkg::*;

   localparam int GRID       = 256;
   localparam int CYCLE_CAP  = 1500000;
   localparam int SETTLE     = 300;
   localparam int LONG_HOLD  = 1500;
   localparam int PHASES     = 10;
   localparam int PHASE_ITEMS = 125;

   typedef struct {
      logic [OPCODE_W-1:0]      opcode;
      logic [POINT_W-1:0]       point;
      logic signed [Q230_W-1:0] amount;
   } string_cmd_t;

   typedef struct {
      logic signed [Q230_W-1:0] displacement;
      logic                     saturated;
   } string_resp_t;

   logic clock;
   logic reset;

   sfd_req_if req_bus ();
   sfd_rsp_if rsp_bus ();
   sfd_csr_if csr_bus ();

   stiff_string_fd_step dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the string state and registers
   logic signed [31:0] grid_mem [3][GRID];
   int unsigned        role_rot;
   sfd_coef_type       weights;
   logic [7:0]         seg_count;
   logic [7:0]         pickup_idx;

   string_cmd_t  pending_cmds [$];
   string_resp_t expected_resp [$];
   bit           failed;
   bit           steady;
   bit           hold_kick;
   int           hold_left;
   int           send_gap;
   longint       cycle_count;

   // exact floor of c*x / 2^28
   function automatic longint weigh(logic signed [31:0] x, logic signed [31:0] c);
      longint p;
      p = longint'(x) * longint'(c);
      return p >>> COEF_FRAC;
   endfunction

   function automatic logic signed [31:0] clip32(longint v, inout bit hit);
      if (v > 64'sd2147483647) begin
         hit = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         hit = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // advance the shadow string by one command and give the response it causes
   function automatic string_resp_t apply_cmd(string_cmd_t cmd);
      string_resp_t res;
      bit           hit;
      int           nx, cu, pv, n;
      longint       acc;
      hit = 1'b0;
      res.displacement = '0;
      nx = role_rot % 3;
      cu = (role_rot + 1) % 3;
      pv = (role_rot + 2) % 3;
      if (cmd.opcode == OP_STEP) begin
         n = seg_count;
         for (int l = 0; l < GRID; l++) begin
            if (l >= 2 && l + 2 <= n) begin
               acc = weigh(grid_mem[cu][l], weights.centre)
                   + weigh(grid_mem[cu][l+1], weights.near)
                   + weigh(grid_mem[cu][l-1], weights.near)
                   + weigh(grid_mem[cu][l+2], weights.far)
                   + weigh(grid_mem[cu][l-2], weights.far)
                   + weigh(grid_mem[pv][l], weights.prev_centre)
                   + weigh(grid_mem[pv][l+1], weights.prev_near)
                   + weigh(grid_mem[pv][l-1], weights.prev_near);
               grid_mem[nx][l] = clip32(acc, hit);
            end else begin
               grid_mem[nx][l] = '0;
            end
         end
         role_rot = (role_rot + 2) % 3;
         res.displacement = grid_mem[(role_rot + 1) % 3][pickup_idx];
      end else if (cmd.opcode == OP_ADD) begin
         grid_mem[cu][cmd.point] = clip32(longint'(grid_mem[cu][cmd.point])
                                          + longint'(cmd.amount), hit);
         grid_mem[pv][cmd.point] = clip32(longint'(grid_mem[pv][cmd.point])
                                          + longint'(cmd.amount), hit);
         res.displacement = grid_mem[cu][cmd.point];
      end else begin
         // read, opcode three included
         res.displacement = grid_mem[cu][cmd.point];
      end
      res.saturated = hit;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // request driver, a new beat only once the previous one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_resp = {expected_resp, apply_cmd('{req_bus.opcode, req_bus.point,
                                                        req_bus.amount})};
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               string_cmd_t c;
               c = pending_cmds.pop_front();
               req_bus.valid  <= 1'b1;
               req_bus.opcode <= c.opcode;
               req_bus.point  <= c.point;
               req_bus.amount <= c.amount;
               send_gap <= pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   bit hold_seen;
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_seen != hold_kick) begin
         hold_seen <= hold_kick;
         hold_left <= LONG_HOLD;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor and random back-pressure
   int rsp_gap;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_resp.size() == 0) begin
               $error("response beat with nothing expected: displacement %0d",
                      rsp_bus.displacement);
               failed = 1'b1;
            end else begin
               string_resp_t e;
               e = expected_resp.pop_front();
               if (rsp_bus.displacement !== e.displacement) begin
                  $error("displacement expected %0d actual %0d",
                         e.displacement, rsp_bus.displacement);
                  failed = 1'b1;
               end
               if (rsp_bus.saturated !== e.saturated) begin
                  $error("saturated expected %0b actual %0b",
                         e.saturated, rsp_bus.saturated);
                  failed = 1'b1;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_gap <= pick_gap();
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // one register write beat, called at a rising edge; valid stays up for the next
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_COEF_CENTRE:      weights.centre      = value;
         CSR_COEF_NEAR:        weights.near        = value;
         CSR_COEF_FAR:         weights.far         = value;
         CSR_COEF_PREV_CENTRE: weights.prev_centre = value;
         CSR_COEF_PREV_NEAR:   weights.prev_near   = value;
         CSR_SEGMENTS:         seg_count           = value[7:0];
         CSR_PICKUP_POINT:     pickup_idx          = value[7:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_cmds.size() > 0 || req_bus.valid || expected_resp.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic push_cmd(logic [OPCODE_W-1:0] op, logic [7:0] pt, logic [31:0] amt);
      string_cmd_t c;
      c.opcode = op;
      c.point  = pt;
      c.amount = amt;
      pending_cmds = {pending_cmds, c};
   endtask

   function automatic logic [31:0] rand_amount();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return $urandom();
      if (r < 8) return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      if (r == 8) return 32'h7FFF_FFFF;
      return 32'h8000_0000;
   endfunction

   function automatic logic [7:0] rand_point();
      if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, seg_count));
      return 8'($urandom());
   endfunction

   initial begin
      logic [31:0] cf [5];
      logic [7:0]  sg, pk;
      int          r;
      failed = 1'b0;
      steady = 1'b0;
      hold_kick = 1'b0;
      cycle_count = 0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_STEP;
      req_bus.point = '0;
      req_bus.amount = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_COEF_CENTRE;
      csr_bus.data = '0;
      for (int s = 0; s < 3; s++)
         for (int i = 0; i < GRID; i++) grid_mem[s][i] = '0;
      role_rot = 0;
      weights = '0;
      seg_count = 8'd255;
      pickup_idx = 8'd0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed beats with registers at reset values
      push_cmd(OP_READ, 8'd0, 32'd0);
      push_cmd(OP_READ, 8'd255, 32'd0);
      push_cmd(OP_ADD, 8'd3, 32'h7FFF_FFFF);
      push_cmd(OP_ADD, 8'd3, 32'h7FFF_FFFF);
      push_cmd(OP_ADD, 8'd3, 32'h8000_0000);
      push_cmd(OP_ADD, 8'd3, 32'h8000_0000);
      push_cmd(OP_ADD, 8'd0, 32'h1234_5678);
      push_cmd(OP_ADD, 8'd255, 32'hFFFF_FFFF);
      push_cmd(2'd3, 8'd3, 32'd0);
      push_cmd(OP_STEP, 8'd0, 32'd0);
      push_cmd(OP_READ, 8'd0, 32'd0);
      push_cmd(OP_STEP, 8'd0, 32'd0);
      push_cmd(OP_READ, 8'd255, 32'd0);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         // per-phase register settings, extremes first
         case (p)
            0: begin
               cf = '{32'sh1C00_0000, 32'sh0333_3333, -32'sh0080_0000,
                      -32'sh0F00_0000, 32'sh0040_0000};
               sg = 8'd255; pk = 8'd10;
            end
            1: begin
               cf = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF};
               sg = 8'd4; pk = 8'd2;
            end
            2: begin
               cf = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000};
               sg = 8'd255; pk = 8'd255;
            end
            3: begin
               foreach (cf[i]) cf[i] = $urandom();
               sg = 8'd3; pk = 8'd0;
            end
            4: begin
               foreach (cf[i]) cf[i] = $urandom();
               sg = 8'd0; pk = 8'd1;
            end
            default: begin
               foreach (cf[i]) cf[i] = 32'($signed($urandom_range(0, 1 << 29))
                                          - (1 << 28));
               sg = 8'($urandom_range(4, 255));
               pk = 8'($urandom_range(0, sg));
            end
         endcase
         write_reg(CSR_COEF_CENTRE, cf[0]);
         write_reg(CSR_COEF_NEAR, cf[1]);
         write_reg(CSR_COEF_FAR, cf[2]);
         write_reg(CSR_COEF_PREV_CENTRE, cf[3]);
         write_reg(CSR_COEF_PREV_NEAR, cf[4]);
         write_reg(CSR_SEGMENTS, {24'd0, sg});
         write_reg(CSR_PICKUP_POINT, {24'd0, pk});
         csr_bus.valid <= 1'b0;

         steady = (p == 5);
         if (p == 0) begin
            // excitation near the pickup, then let it travel
            push_cmd(OP_ADD, 8'd10, 32'h1000_0000);
            push_cmd(OP_ADD, 8'd11, 32'h0800_0000);
            push_cmd(OP_STEP, 8'd0, 32'd0);
            push_cmd(OP_STEP, 8'd0, 32'd0);
            push_cmd(OP_READ, 8'd12, 32'd0);
         end
         if (p == 6) hold_kick = ~hold_kick;

         // random mix of steps, adds, reads and opcode-three beats
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30)      push_cmd(OP_STEP, 8'($urandom()), rand_amount());
            else if (r < 65) push_cmd(OP_ADD, rand_point(), rand_amount());
            else if (r < 95) push_cmd(OP_READ, rand_point(), 32'($urandom()));
            else             push_cmd(2'd3, rand_point(), 32'($urandom()));
         end
         wait_idle();
      end

      repeat (SETTLE) @(posedge clock);
      if (!failed && expected_resp.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
